### sv/assert_macros.svh
// Assertion macros shared by the display command queue scheduler RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held.
`define DCQS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcqs assertion failed");
// Next-cycle implication, disabled while reset is held.
`define DCQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcqs assertion failed");
`else
`define DCQS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define DCQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/dcqs_pkg.sv
// Types and constants of the display command queue scheduler.
// No dependencies; used by the packer and the top level.
`default_nettype none

package dcqs_pkg;

    localparam int WORDS_PER_CMD = 4;
    localparam int WORD_W        = 9;
    localparam int BYTE_W        = 8;
    localparam int COUNT_W       = 3;
    localparam int LEN_W         = 16;

    localparam logic [WORD_W-1:0]  CMD_DATA_FLAG       = 9'h100;
    localparam logic [LEN_W-1:0]   STREAM_LENGTH_RESET = 16'd26144;
    localparam logic [COUNT_W-1:0] MAX_WORD_COUNT      = 3'd4;

    typedef enum logic [1:0] {
        ACT_ENQUEUE    = 2'd0,
        ACT_TICK       = 2'd1,
        ACT_DONE       = 2'd2,
        ACT_STREAM_REQ = 2'd3
    } t_action;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [WORDS_PER_CMD-1:0] t_words;

    // One input word of the command channel.
    typedef struct packed {
        t_action            action;
        logic [BYTE_W-1:0]  byte_0;
        logic [BYTE_W-1:0]  byte_1;
        logic [BYTE_W-1:0]  byte_2;
        logic [BYTE_W-1:0]  byte_3;
        logic [COUNT_W-1:0] word_count;
        logic               trailing_nop;
    } t_in;

    // One result word.
    typedef struct packed {
        logic              start_transfer;
        t_word             out_word_0;
        t_word             out_word_1;
        t_word             out_word_2;
        t_word             out_word_3;
        logic [LEN_W-1:0]  transfer_length;
        logic              stream_mode;
        logic              link_busy;
    } t_out;

    // Contents of one queue slot.
    typedef struct packed {
        t_words             words;
        logic [COUNT_W-1:0] length;
    } t_slot;

endpackage

`default_nettype wire

### sv/dcqs_chan_if.sv
// Valid/ready channel carrying one payload word of a chosen type.
// Used with the types of dcqs_pkg by the top level.
`default_nettype none

interface dcqs_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/dcqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the command slots of the queue.
`default_nettype none

module dcqs_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; a read of the written address returns old data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### sv/dcqs_packer.sv
// Formats an enqueued command into the 9-bit words of one queue slot.
// Depends on dcqs_pkg.
`default_nettype none

module dcqs_packer
    import dcqs_pkg::*;
(
    input  wire t_in   i_cmd,
    output t_slot      o_slot
);

    logic [COUNT_W-1:0] count;
    t_words             raw;

    // Counts above four saturate.
    assign count = (i_cmd.word_count > MAX_WORD_COUNT) ? MAX_WORD_COUNT : i_cmd.word_count;

    // Word 0 is the command; data words carry the flag, word 3 only when no no-op follows.
    always_comb begin
        raw[0] = {1'b0, i_cmd.byte_0};
        raw[1] = {1'b0, i_cmd.byte_1} | CMD_DATA_FLAG;
        raw[2] = {1'b0, i_cmd.byte_2} | CMD_DATA_FLAG;
        raw[3] = i_cmd.trailing_nop ? {1'b0, i_cmd.byte_3} : ({1'b0, i_cmd.byte_3} | CMD_DATA_FLAG);
    end

    // Words past the count are stored as zero.
    always_comb begin
        for (int k = 0; k < WORDS_PER_CMD; k++) begin
            o_slot.words[k] = (COUNT_W'(k) < count) ? raw[k] : '0;
        end
        o_slot.length = count;
    end

endmodule

`default_nettype wire

### sv/display_command_queue_scheduler.sv
// Display command queue scheduler: a ring of command slots and a three-phase link scheduler.
// Depends on dcqs_pkg, dcqs_chan_if, dcqs_ram, dcqs_packer and assert_macros.svh.
//
// i_cmd carries one word per event: enqueue a command, scheduler tick, transfer done or
// stream-mode request. Every accepted word yields exactly one result word on o_res, which
// reports whether that tick launches a transfer, the words and length of the transfer, and
// whether stream mode is on and the link busy. i_cfg writes the stream transfer length and
// is always ready; write it only while the block is idle.
// An accepted word waits in the input register and is then written into the result register.
// One word is accepted every cycle while o_res is not stalled: an input register feeds one
// stage of logic into the result register. The slot store is a RAM whose read address is
// the next value of the scan pointer, with a bypass for a slot written in the same cycle,
// so no tick waits on it.
// Reset empties the queue, sets both pointers to slot zero, the scheduler to its check
// phase and the stream length to 26144; the slot RAM itself is not cleared.
// When o_res is stalled the result register holds its word, one further word waits in the
// input register, and i_cmd then deasserts ready until the result is taken.
`default_nettype none
`include "assert_macros.svh"

module display_command_queue_scheduler
    import dcqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dcqs_chan_if.sink  i_cmd,
    dcqs_chan_if.sink  i_cfg,
    dcqs_chan_if.source o_res
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        PH_CHECK = 2'd0,
        PH_START = 2'd1,
        PH_END   = 2'd2
    } t_phase;

    // Registers
    logic                   r_in_valid;
    t_in                    r_in;
    logic                   r_out_valid;
    t_out                   r_out;
    logic [LEN_W-1:0]       r_stream_len;
    logic [QUEUE_DEPTH-1:0] r_slot_valid;
    logic [PTR_W-1:0]       r_wp;
    logic [PTR_W-1:0]       r_scan;
    t_phase                 r_phase;
    t_words                 r_cur_words;
    logic [LEN_W-1:0]       r_cur_len;
    logic                   r_done;
    logic                   r_req;
    logic                   r_stream;
    logic                   r_byp_hit;
    t_slot                  r_byp_data;

    // Next values
    logic [QUEUE_DEPTH-1:0] n_slot_valid;
    logic [PTR_W-1:0]       n_wp;
    logic [PTR_W-1:0]       n_scan;
    t_phase                 n_phase;
    t_words                 n_cur_words;
    logic [LEN_W-1:0]       n_cur_len;
    logic                   n_done;
    logic                   n_req;
    logic                   n_stream;
    t_out                   n_out;

    logic   w_proc;
    logic   w_started;
    logic   w_take;
    logic   w_grant;
    logic   wr_en;
    t_slot  packed_slot;
    t_slot  ram_rd;
    t_slot  scan_slot;

    // Handshakes: the input register advances whenever the result register can take a word.
    assign w_proc      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || w_proc;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    dcqs_packer u_packer (
        .i_cmd  (r_in),
        .o_slot (packed_slot)
    );

    // Slot store, read at the scan pointer of the next cycle.
    dcqs_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (packed_slot),
        .i_rd_addr (n_scan),
        .o_rd_data (ram_rd)
    );

    assign scan_slot = r_byp_hit ? r_byp_data : ram_rd;

    // Event handling for the word in the input register.
    always_comb begin
        n_slot_valid = r_slot_valid;
        n_wp         = r_wp;
        n_scan       = r_scan;
        n_phase      = r_phase;
        n_cur_words  = r_cur_words;
        n_cur_len    = r_cur_len;
        n_done       = r_done;
        n_req        = r_req;
        n_stream     = r_stream;
        w_started    = 1'b0;
        w_take       = 1'b0;
        w_grant      = 1'b0;
        wr_en        = 1'b0;
        if (w_proc) begin
            case (r_in.action)
                ACT_ENQUEUE: begin
                    wr_en              = 1'b1;
                    n_slot_valid[r_wp] = 1'b1;
                    n_wp               = (r_wp == LAST_SLOT) ? '0 : r_wp + 1'b1;
                end
                ACT_TICK: begin
                    case (r_phase)
                        PH_START: begin
                            n_phase   = PH_END;
                            w_started = 1'b1;
                        end
                        PH_END: begin
                            if (r_done) begin
                                n_done  = 1'b0;
                                n_phase = PH_CHECK;
                            end
                        end
                        default: begin
                            // Check phase: take the scanned slot or move on.
                            if (r_slot_valid[r_scan]) begin
                                w_take               = 1'b1;
                                n_cur_words          = scan_slot.words;
                                n_cur_len            = {{(LEN_W-COUNT_W){1'b0}}, scan_slot.length};
                                n_slot_valid[r_scan] = 1'b0;
                                n_phase              = PH_START;
                            end else begin
                                n_scan = (r_scan == LAST_SLOT) ? '0 : r_scan + 1'b1;
                            end
                            // A pending stream request is granted once the queue is empty.
                            if (!r_slot_valid[r_scan] && r_req && !(|r_slot_valid)) begin
                                w_grant     = 1'b1;
                                n_stream    = 1'b1;
                                n_req       = 1'b0;
                                n_cur_words = '0;
                                n_cur_len   = r_stream_len;
                                n_phase     = PH_START;
                            end
                        end
                    endcase
                end
                ACT_DONE: begin
                    n_done = 1'b1;
                end
                default: begin
                    n_req = 1'b1;
                end
            endcase
        end
    end

    // Result word.
    always_comb begin
        n_out.start_transfer  = w_started;
        n_out.out_word_0      = w_started ? r_cur_words[0] : '0;
        n_out.out_word_1      = w_started ? r_cur_words[1] : '0;
        n_out.out_word_2      = w_started ? r_cur_words[2] : '0;
        n_out.out_word_3      = w_started ? r_cur_words[3] : '0;
        n_out.transfer_length = w_started ? r_cur_len : '0;
        n_out.stream_mode     = n_stream;
        n_out.link_busy       = (n_phase == PH_START) || (n_phase == PH_END);
    end

    // State, pipeline registers and the read bypass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_stream_len <= STREAM_LENGTH_RESET;
            r_slot_valid <= '0;
            r_wp         <= '0;
            r_scan       <= '0;
            r_phase      <= PH_CHECK;
            r_done       <= 1'b0;
            r_req        <= 1'b0;
            r_stream     <= 1'b0;
            r_byp_hit    <= 1'b0;
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                r_in_valid <= 1'b1;
                r_in       <= i_cmd.data;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_stream_len <= i_cfg.data;
            end
            r_slot_valid <= n_slot_valid;
            r_wp         <= n_wp;
            r_scan       <= n_scan;
            r_phase      <= n_phase;
            r_cur_words  <= n_cur_words;
            r_cur_len    <= n_cur_len;
            r_done       <= n_done;
            r_req        <= n_req;
            r_stream     <= n_stream;
            r_byp_hit    <= wr_en && (r_wp == n_scan);
            r_byp_data   <= packed_slot;
        end
    end

    // Checks on the scheduler.
    `DCQS_ASSERT_NEXT(a_start_goes_end, i_clk, i_rst_n, w_proc && w_started, r_phase == PH_END)
    `DCQS_ASSERT_NEXT(a_take_goes_start, i_clk, i_rst_n, w_take, r_phase == PH_START)
    `DCQS_ASSERT_NOW(a_grant_empty, i_clk, i_rst_n, w_grant, r_slot_valid == '0)
    `DCQS_ASSERT_NOW(a_full_stall, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !o_res.ready, !i_cmd.ready)

endmodule

`default_nettype wire
